/* design/pibm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pibm_pkg
// Shared widths, codes, state type and control structs for the positional
// insert buffer with running mean.
// ----------------------------------------------------------------------------
package pibm_pkg;

    // array geometry
    localparam int CAPACITY   = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int COUNT_W    = 6;
    localparam int VALUE_W    = 32;
    localparam int SUM_W      = 37;
    localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SHIFT,
        S_SHIFT_WR,
        S_WRITE,
        S_READ,
        S_READ_CAP,
        S_DIV_START,
        S_DIV_RUN,
        S_RESULT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic set_status;
        logic idx_init;
        logic shift_rd;
        logic shift_wr;
        logic ins_write;
        logic rd_issue;
        logic rd_capture;
        logic div_start;
        logic emit;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_read;
        logic ok;
        logic need_shift;
        logic div_done;
    } dp_stat_t;

endpackage

/* design/pibm_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pibm_div
// Restoring divider, one quotient bit per cycle, for the running sum over
// the entry count.
// ----------------------------------------------------------------------------
module pibm_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pibm_pkg::SUM_W-1:0]    dividend,
    input  logic [pibm_pkg::COUNT_W-1:0]  divisor,
    output logic                          done,
    output logic [pibm_pkg::SUM_W-1:0]    quotient
);

    logic                              run_reg;
    logic [pibm_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [pibm_pkg::COUNT_W-1:0]      rem_reg;
    logic [pibm_pkg::SUM_W-1:0]        quo_reg;
    logic [pibm_pkg::COUNT_W-1:0]      div_reg;

    logic [pibm_pkg::COUNT_W:0]        trial;
    logic [pibm_pkg::COUNT_W:0]        diff;
    logic                              fits;

    // one restoring step
    always_comb
    begin
        trial = {rem_reg, quo_reg[pibm_pkg::SUM_W-1]};
        diff  = trial - {1'b0, div_reg};
        fits  = (trial >= {1'b0, div_reg});
    end

    // control: step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
            cnt_reg <= pibm_pkg::DIV_CNT_W'(pibm_pkg::SUM_W);
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == pibm_pkg::DIV_CNT_W'(1))
            begin
                run_reg <= 1'b0;
            end
        end
    end

    // datapath: remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? diff[pibm_pkg::COUNT_W-1:0] : trial[pibm_pkg::COUNT_W-1:0];
            quo_reg <= {quo_reg[pibm_pkg::SUM_W-2:0], fits};
        end
    end

    assign done     = run_reg && (cnt_reg == pibm_pkg::DIV_CNT_W'(1));
    assign quotient = quo_reg;

endmodule

/* design/pibm_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pibm_dp
// Datapath: entry memory, count, running sum, divider and result registers.
// ----------------------------------------------------------------------------
module pibm_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pibm_pkg::dp_cmd_t             cmd,
    output pibm_pkg::dp_stat_t            stat,
    input  logic                          action,
    input  logic [pibm_pkg::VALUE_W-1:0]  value_cents,
    input  logic [pibm_pkg::COUNT_W-1:0]  position,
    output logic                          done,
    output logic [1:0]                    status,
    output logic [pibm_pkg::VALUE_W-1:0]  read_value,
    output logic [pibm_pkg::COUNT_W-1:0]  entry_count,
    output logic [pibm_pkg::VALUE_W-1:0]  mean_cents
);

    // entry memory
    logic [pibm_pkg::VALUE_W-1:0]  mem [pibm_pkg::CAPACITY];
    logic [pibm_pkg::VALUE_W-1:0]  mem_q_reg;

    // latched item and working state
    logic                          action_reg;
    logic [pibm_pkg::VALUE_W-1:0]  value_reg;
    logic [pibm_pkg::COUNT_W-1:0]  pos_reg;
    logic [pibm_pkg::COUNT_W-1:0]  idx_reg;
    logic [pibm_pkg::COUNT_W-1:0]  count_reg;
    logic [pibm_pkg::SUM_W-1:0]    sum_reg;
    logic [1:0]                    code_reg;
    logic [pibm_pkg::VALUE_W-1:0]  rdval_reg;

    // result registers
    logic                          done_reg;
    logic [1:0]                    status_reg;
    logic [pibm_pkg::VALUE_W-1:0]  read_value_reg;
    logic [pibm_pkg::COUNT_W-1:0]  entry_count_reg;
    logic [pibm_pkg::VALUE_W-1:0]  mean_reg;

    logic [1:0]                    code_next;
    logic [pibm_pkg::COUNT_W-1:0]  idx_dec;
    logic [pibm_pkg::ADDR_W-1:0]   rd_addr;
    logic [pibm_pkg::ADDR_W-1:0]   wr_addr;
    logic [pibm_pkg::VALUE_W-1:0]  wr_data;
    logic                          div_done;
    logic [pibm_pkg::SUM_W-1:0]    quotient;

    // status decision for the latched item
    always_comb
    begin
        if (action_reg == pibm_pkg::ACT_INSERT)
        begin
            if (count_reg >= pibm_pkg::COUNT_W'(pibm_pkg::CAPACITY))
            begin
                code_next = pibm_pkg::ST_FULL;
            end
            else if (pos_reg > count_reg)
            begin
                code_next = pibm_pkg::ST_RANGE;
            end
            else
            begin
                code_next = pibm_pkg::ST_OK;
            end
        end
        else
        begin
            code_next = (pos_reg < count_reg) ? pibm_pkg::ST_OK : pibm_pkg::ST_RANGE;
        end
    end

    // memory addressing
    always_comb
    begin
        idx_dec = idx_reg - 1'b1;
        rd_addr = cmd.shift_rd ? idx_dec[pibm_pkg::ADDR_W-1:0] : pos_reg[pibm_pkg::ADDR_W-1:0];
        wr_addr = cmd.shift_wr ? idx_reg[pibm_pkg::ADDR_W-1:0] : pos_reg[pibm_pkg::ADDR_W-1:0];
        wr_data = cmd.shift_wr ? mem_q_reg : value_reg;
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.shift_wr || cmd.ins_write)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.shift_rd || cmd.rd_issue)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // item latch and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action;
            value_reg  <= value_cents;
            pos_reg    <= position;
            rdval_reg  <= '0;
        end
        if (cmd.set_status)
        begin
            code_reg <= code_next;
        end
        if (cmd.idx_init)
        begin
            idx_reg <= count_reg;
        end
        else if (cmd.shift_wr)
        begin
            idx_reg <= idx_dec;
        end
        if (cmd.rd_capture)
        begin
            rdval_reg <= mem_q_reg;
        end
    end

    // count and running sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else if (cmd.ins_write)
        begin
            count_reg <= count_reg + 1'b1;
            sum_reg   <= sum_reg + pibm_pkg::SUM_W'(value_reg);
        end
    end

    pibm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg      <= code_reg;
            read_value_reg  <= rdval_reg;
            entry_count_reg <= count_reg;
            mean_reg        <= (count_reg == '0) ? '0 : quotient[pibm_pkg::VALUE_W-1:0];
        end
    end

    // status to controller
    always_comb
    begin
        stat.is_read    = (action_reg == pibm_pkg::ACT_READ);
        stat.ok         = (code_next == pibm_pkg::ST_OK);
        stat.need_shift = (idx_reg > pos_reg);
        stat.div_done   = div_done;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign read_value  = read_value_reg;
    assign entry_count = entry_count_reg;
    assign mean_cents  = mean_reg;

endmodule

/* design/pibm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pibm_ctrl
// Controller: sequences latch, decision, shift, write or read, divide and
// result for one item at a time.
// ----------------------------------------------------------------------------
module pibm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  pibm_pkg::dp_stat_t  stat,
    output pibm_pkg::dp_cmd_t   cmd,
    output logic                busy
);

    pibm_pkg::state_t state_reg;
    pibm_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pibm_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pibm_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = pibm_pkg::S_DECIDE;
                end
            end
            pibm_pkg::S_DECIDE:
            begin
                if (!stat.ok)
                begin
                    state_next = pibm_pkg::S_DIV_START;
                end
                else if (stat.is_read)
                begin
                    state_next = pibm_pkg::S_READ;
                end
                else
                begin
                    state_next = pibm_pkg::S_SHIFT;
                end
            end
            pibm_pkg::S_SHIFT:
            begin
                state_next = stat.need_shift ? pibm_pkg::S_SHIFT_WR : pibm_pkg::S_WRITE;
            end
            pibm_pkg::S_SHIFT_WR:  state_next = pibm_pkg::S_SHIFT;
            pibm_pkg::S_WRITE:     state_next = pibm_pkg::S_DIV_START;
            pibm_pkg::S_READ:      state_next = pibm_pkg::S_READ_CAP;
            pibm_pkg::S_READ_CAP:  state_next = pibm_pkg::S_DIV_START;
            pibm_pkg::S_DIV_START: state_next = pibm_pkg::S_DIV_RUN;
            pibm_pkg::S_DIV_RUN:
            begin
                if (stat.div_done)
                begin
                    state_next = pibm_pkg::S_RESULT;
                end
            end
            pibm_pkg::S_RESULT:    state_next = pibm_pkg::S_IDLE;
            default:               state_next = pibm_pkg::S_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            pibm_pkg::S_IDLE:      cmd.load = start;
            pibm_pkg::S_DECIDE:
            begin
                cmd.set_status = 1'b1;
                cmd.idx_init   = 1'b1;
            end
            pibm_pkg::S_SHIFT:     cmd.shift_rd   = stat.need_shift;
            pibm_pkg::S_SHIFT_WR:  cmd.shift_wr   = 1'b1;
            pibm_pkg::S_WRITE:     cmd.ins_write  = 1'b1;
            pibm_pkg::S_READ:      cmd.rd_issue   = 1'b1;
            pibm_pkg::S_READ_CAP:  cmd.rd_capture = 1'b1;
            pibm_pkg::S_DIV_START: cmd.div_start  = 1'b1;
            pibm_pkg::S_DIV_RUN:   cmd = '0;
            pibm_pkg::S_RESULT:    cmd.emit       = 1'b1;
            default:               cmd = '0;
        endcase
    end

    assign busy = (state_reg != pibm_pkg::S_IDLE);

endmodule

/* design/positional_insert_buffer_with_mean.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_insert_buffer_with_mean
// Bounded array of cent values with insert-at-position, indexed read and a
// truncated running mean reported with every result.
// ----------------------------------------------------------------------------
// An item is taken when start is high while busy is low; its result appears
// on the result ports for one cycle with done high, and must be taken then,
// as the block cannot hold it. The block works on one item at a time: a
// successful read reads and captures the entry, a refused insert or read
// goes straight to the divide, and an accepted insert first moves k entries
// up to make room (up to 31), then writes the value. The mean comes
// from a one-bit-per-cycle restoring divide of the 37-bit sum by the count,
// run for every item, and each moved entry costs a read and a write of the
// entry memory, which has separate read and write addresses. A new item
// may be given in the cycle that done is high.
// ----------------------------------------------------------------------------
module positional_insert_buffer_with_mean (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          action,
    input  logic [pibm_pkg::VALUE_W-1:0]  value_cents,
    input  logic [pibm_pkg::COUNT_W-1:0]  position,
    output logic                          done,
    output logic [1:0]                    status,
    output logic [pibm_pkg::VALUE_W-1:0]  read_value,
    output logic [pibm_pkg::COUNT_W-1:0]  entry_count,
    output logic [pibm_pkg::VALUE_W-1:0]  mean_cents
);

    pibm_pkg::dp_cmd_t  cmd;
    pibm_pkg::dp_stat_t stat;

    // controller
    pibm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // datapath
    pibm_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .action      (action),
        .value_cents (value_cents),
        .position    (position),
        .done        (done),
        .status      (status),
        .read_value  (read_value),
        .entry_count (entry_count),
        .mean_cents  (mean_cents)
    );

    // result strobe only once the controller is back to idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // a taken item makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("item taken but block not busy");

    // a full refusal only when the array is at capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == pibm_pkg::ST_FULL)
            |-> entry_count == pibm_pkg::COUNT_W'(pibm_pkg::CAPACITY))
        else $error("full status with spare room");

    // failed items never return data
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != pibm_pkg::ST_OK) |-> read_value == '0)
        else $error("read value on refused item");

endmodule
